/* hw/rtl/box_table_edge_contact_unit_defines.svh */
// Assertion macros for the box table edge contact unit.
`ifndef BOX_TABLE_EDGE_CONTACT_UNIT_DEFINES_SVH
`define BOX_TABLE_EDGE_CONTACT_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define BTEC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define BTEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BTEC_ASSERT_NOW(lbl, ante, cons, msg)
`define BTEC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/btec_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package btec_pkg;

  localparam int EDGE_W = 17;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DEL   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0] edge_left;
    logic signed [EDGE_W-1:0] edge_top;
    logic signed [EDGE_W-1:0] edge_right;
    logic signed [EDGE_W-1:0] edge_bottom;
    logic [3:0]               flags;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic signed [EDGE_W-1:0] rx;
    logic signed [EDGE_W-1:0] ry;
    logic signed [EDGE_W-1:0] rxr;
    logic signed [EDGE_W-1:0] ryb;
  } rect_t;

  typedef struct packed {
    logic up;
    logic down;
    logic right;
    logic left;
  } hits_t;

endpackage

`default_nettype wire

/* hw/rtl/btec_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module btec_ram #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/btec_contact.sv */
`timescale 1ns / 1ps
`default_nettype none

module btec_contact
  import btec_pkg::*;
(
  input  wire entry_t ent,
  input  wire rect_t  rect,
  output hits_t       hits
);

  logic ovx;
  logic ovy;

  // Strict overlap on each axis; contact needs the edge match plus overlap on the other axis.
  assign ovx = (rect.rx < ent.edge_right) && (rect.rxr > ent.edge_left);
  assign ovy = (rect.ry < ent.edge_bottom) && (rect.ryb > ent.edge_top);

  assign hits.up    = ent.flags[0] && (rect.ry == ent.edge_bottom) && ovx;
  assign hits.down  = ent.flags[1] && (rect.ryb == ent.edge_top) && ovx;
  assign hits.right = ent.flags[2] && (rect.rxr == ent.edge_left) && ovy;
  assign hits.left  = ent.flags[3] && (rect.rx == ent.edge_right) && ovy;

endmodule

`default_nettype wire

/* hw/rtl/box_table_edge_contact_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "box_table_edge_contact_unit_defines.svh"

// Box table with an edge contact test.
// A transaction is taken at a rising edge with start high and busy low. The opcode selects
// an add of a box (x, y, w, h and side enables), a delete of the entry at entry_index, or a
// contact query with a rectangle. Each transaction gives exactly one result, shown for one
// cycle with out_valid high; the receiver cannot stall it and must take it then.
// The table sits in one single-port-read, single-port-write RAM of MAX_BOXES entries.
// An add, a no-op, a full-table add, a bad-index delete, a query of an empty table and a
// delete of the last entry give their result in the next cycle and busy stays low, so such
// transactions can follow back to back.
// A query of N held boxes reads the RAM once per cycle and tests each entry in one shared
// contact unit, OR-ing the hits; busy stays high through the S_SCAN and S_WAIT states.
// A delete at index i of N boxes moves N - i - 1 entries down, one RAM read and one write a
// cycle; busy stays high through the S_SCAN and S_WAIT states.
// Reset clears the box count and control state; the RAM contents are not cleared and are only
// read below the count.
module box_table_edge_contact_unit
  import btec_pkg::*;
#(
  parameter int MAX_BOXES = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         in_opcode,
  input  wire logic signed [15:0] in_rect_x,
  input  wire logic signed [15:0] in_rect_y,
  input  wire logic [14:0]        in_rect_w,
  input  wire logic [14:0]        in_rect_h,
  input  wire logic [3:0]         in_side_enable,
  input  wire logic [5:0]         in_entry_index,
  output logic                    out_valid,
  output logic                    out_hit_up,
  output logic                    out_hit_down,
  output logic                    out_hit_right,
  output logic                    out_hit_left,
  output logic [1:0]              out_status,
  output logic [6:0]              out_box_count
);

  localparam int AW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int IW = (CW > 7) ? CW : 7;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    ptr_r, ptr_nxt;
  logic [AW-1:0]    rd_addr_r, rd_addr_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             rd_last_r, rd_last_nxt;
  opcode_t          op_r, op_nxt;
  rect_t            rect_r, rect_nxt;
  hits_t            acc_r, acc_nxt;
  logic             out_valid_r, out_valid_nxt;
  hits_t            out_hits_r, out_hits_nxt;
  status_t          out_status_r, out_status_nxt;
  logic [6:0]       out_count_r, out_count_nxt;

  logic             accept;
  opcode_t          in_op;
  logic [IW-1:0]    idx_ext;
  logic [IW-1:0]    count_ext;
  logic             table_full;
  logic             del_bad;
  logic             del_tail;
  logic             del_shift;
  logic             query_scan;
  logic             scan_last;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic             ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t           new_entry;
  entry_t           rd_entry;
  hits_t            hit_now;
  rect_t            in_rect;

  assign accept     = start && !busy;
  assign in_op      = opcode_t'(in_opcode);
  assign idx_ext    = IW'(in_entry_index);
  assign count_ext  = IW'(count_r);
  assign table_full = (count_r == CW'(MAX_BOXES));
  assign del_bad    = (idx_ext >= count_ext);
  assign del_tail   = ((idx_ext + 1'b1) == count_ext);
  assign del_shift  = accept && (in_op == OP_DEL) && !del_bad && !del_tail;
  assign query_scan = accept && (in_op == OP_QUERY) && (count_r != '0);
  assign scan_last  = (ptr_r == AW'(count_r - 1'b1));

  assign in_rect.rx  = {in_rect_x[15], in_rect_x};
  assign in_rect.ry  = {in_rect_y[15], in_rect_y};
  assign in_rect.rxr = {in_rect_x[15], in_rect_x} + {2'b00, in_rect_w};
  assign in_rect.ryb = {in_rect_y[15], in_rect_y} + {2'b00, in_rect_h};

  assign new_entry.edge_left   = in_rect.rx;
  assign new_entry.edge_top    = in_rect.ry;
  assign new_entry.edge_right  = in_rect.rxr;
  assign new_entry.edge_bottom = in_rect.ryb;
  assign new_entry.flags       = in_side_enable;

  assign rd_entry = entry_t'(ram_rdata);

  btec_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BOXES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  btec_contact u_contact (
    .ent  (rd_entry),
    .rect (rect_r),
    .hits (hit_now)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (del_shift || query_scan) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (rd_last_r) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    rd_addr_nxt    = rd_addr_r;
    rd_vld_nxt     = 1'b0;
    rd_last_nxt    = 1'b0;
    op_nxt         = op_r;
    rect_nxt       = rect_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = 1'b0;
    out_hits_nxt   = out_hits_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = AW'(count_r);
    ram_wdata      = new_entry;
    ram_re         = 1'b0;

    if (state_r == S_IDLE && accept) begin
      op_nxt         = in_op;
      rect_nxt       = in_rect;
      acc_nxt        = '0;
      out_hits_nxt   = '0;
      out_status_nxt = ST_OK;
      out_valid_nxt  = 1'b1;
      unique case (in_op)
        OP_ADD: begin
          if (table_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_DEL: begin
          if (del_bad) begin
            out_status_nxt = ST_BAD_INDEX;
          end else if (del_tail) begin
            count_nxt = count_r - 1'b1;
          end else begin
            out_valid_nxt = 1'b0;
            ptr_nxt       = AW'(idx_ext + 1'b1);
          end
        end
        OP_QUERY: begin
          if (count_r != '0) begin
            out_valid_nxt = 1'b0;
            ptr_nxt       = '0;
          end
        end
        default: begin
        end
      endcase
      out_count_nxt = 7'(count_nxt);
    end

    if (state_r == S_SCAN) begin
      ram_re      = 1'b1;
      rd_vld_nxt  = 1'b1;
      rd_addr_nxt = ptr_r;
      rd_last_nxt = scan_last;
      ptr_nxt     = ptr_r + 1'b1;
    end

    if (rd_vld_r) begin
      if (op_r == OP_QUERY) begin
        acc_nxt = acc_r | hit_now;
      end else begin
        ram_we    = 1'b1;
        ram_waddr = rd_addr_r - 1'b1;
        ram_wdata = ram_rdata;
      end
      if (rd_last_r) begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_OK;
        if (op_r == OP_QUERY) begin
          out_hits_nxt = acc_r | hit_now;
        end else begin
          out_hits_nxt = '0;
          count_nxt    = count_r - 1'b1;
        end
        out_count_nxt = 7'(count_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      rd_last_r   <= rd_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    rd_addr_r    <= rd_addr_nxt;
    op_r         <= op_nxt;
    rect_r       <= rect_nxt;
    acc_r        <= acc_nxt;
    out_hits_r   <= out_hits_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign busy          = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_hit_up    = out_hits_r.up;
  assign out_hit_down  = out_hits_r.down;
  assign out_hit_right = out_hits_r.right;
  assign out_hit_left  = out_hits_r.left;
  assign out_status    = out_status_r;
  assign out_box_count = out_count_r;

  `BTEC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(MAX_BOXES),
    "box count exceeds table size")
  `BTEC_ASSERT_NEXT(a_add_grows, accept && (in_op == OP_ADD) && !table_full,
    count_r == $past(count_r) + 1'b1, "add did not grow the table")
  `BTEC_ASSERT_NOW(a_read_in_scan, rd_vld_r, state_r != S_IDLE,
    "read data returned outside a scan")
  `BTEC_ASSERT_NOW(a_full_count, out_valid_r && (out_status_r == ST_FULL),
    out_count_r == 7'(MAX_BOXES), "full status with a table that is not full")
  `BTEC_ASSERT_NEXT(a_scan_result, rd_vld_r && rd_last_r, out_valid_r && !busy,
    "scan ended without a result")

endmodule

`default_nettype wire
